// ===== sv/stepper_motion_pulse_controller_assert.svh =====
`ifndef STEPPER_MOTION_PULSE_CONTROLLER_ASSERT_SVH
`define STEPPER_MOTION_PULSE_CONTROLLER_ASSERT_SVH

// Property checked at every rising clock edge, held off while reset is asserted.
`define SMPC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("smpc check failed");

// Trigger in one cycle, expectation in the next.
`define SMPC_ASSERT_NEXT(label, trig, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error("smpc check failed");

`endif

// ===== sv/smpc_pkg.sv =====
package smpc_pkg;

	localparam int TICK_HZ    = 1000000;
	localparam int COUNT_BITS = 24;

	localparam longint unsigned DIVIDEND = 60 * longint'(TICK_HZ);
	localparam int DIVIDEND_BITS = $clog2(DIVIDEND + 1);
	localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS);

	localparam int PULSE_BITS  = 24;
	localparam int RPM_BITS    = 12;
	localparam int SPR_BITS    = 11;
	localparam int MST_BITS    = 9;
	localparam int P1_BITS     = RPM_BITS + SPR_BITS;
	localparam int PROD_BITS   = P1_BITS + MST_BITS;
	localparam int PERIOD_BITS = 16;
	localparam int PERIOD_MIN  = 10;
	localparam int PERIOD_MAX  = 65535;

	localparam int CMP_BITS = (DIVIDEND_BITS + 1 > PROD_BITS) ? DIVIDEND_BITS + 1 : PROD_BITS;
	localparam int QUO_EXT_BITS = (DIVIDEND_BITS > PERIOD_BITS + 1) ? DIVIDEND_BITS
		: PERIOD_BITS + 1;

	localparam int SPR_RESET = 200;
	localparam int MST_RESET = 16;

	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;

	typedef enum logic [2:0] {
		ACT_TICK,
		ACT_FWD,
		ACT_REV,
		ACT_HOME,
		ACT_END,
		ACT_STOP,
		ACT_PAUSE,
		ACT_RESUME
	} action_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_PULSE,
		MODE_HOME,
		MODE_END
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_DIV,
		ST_APPLY
	} ctrl_state_t;

	typedef enum logic {
		REG_SPR,
		REG_MST
	} reg_idx_t;

	typedef struct packed {
		logic take;
		logic apply_live;
		logic mul1;
		logic mul2;
		logic div_step;
		logic apply_saved;
	} smpc_cmd_t;

	typedef struct packed {
		logic slow;
		logic div_last;
	} smpc_sts_t;

endpackage

// ===== sv/smpc_if.sv =====
interface smpc_in_if;
	logic                                valid;
	logic                                ready;
	smpc_pkg::action_t                   action;
	logic [smpc_pkg::PULSE_BITS-1:0]     pulse_count;
	logic [smpc_pkg::RPM_BITS-1:0]       speed_rpm;
	logic                                home_level;
	logic                                end_level;

	modport source (
		output valid, action, pulse_count, speed_rpm, home_level, end_level,
		input  ready
	);
	modport sink (
		input  valid, action, pulse_count, speed_rpm, home_level, end_level,
		output ready
	);
endinterface

interface smpc_out_if;
	logic valid;
	logic ready;
	logic step_out;
	logic dir_out;
	logic drive_enabled;
	logic busy_res;
	logic move_done;
	logic pulse_event;

	modport source (
		output valid, step_out, dir_out, drive_enabled, busy_res, move_done, pulse_event,
		input  ready
	);
	modport sink (
		input  valid, step_out, dir_out, drive_enabled, busy_res, move_done, pulse_event,
		output ready
	);
endinterface

// ===== sv/smpc_ctrl.sv =====
module smpc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  smpc_pkg::smpc_sts_t  sts,
	output smpc_pkg::smpc_cmd_t  cmd
);

	smpc_pkg::ctrl_state_t state_q, state_n;
	logic out_valid_q, out_valid_n;
	logic out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= smpc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			out_valid_q <= out_valid_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		out_free = !out_valid_q || out_ready;
		case (state_q)
			smpc_pkg::ST_IDLE: begin
				in_ready = out_free;
				if (in_valid && out_free) begin
					cmd.take = 1'b1;
					if (sts.slow) begin
						state_n = smpc_pkg::ST_MUL1;
					end else begin
						cmd.apply_live = 1'b1;
					end
				end
			end
			smpc_pkg::ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_n  = smpc_pkg::ST_MUL2;
			end
			smpc_pkg::ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_n  = smpc_pkg::ST_DIV;
			end
			smpc_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_n = smpc_pkg::ST_APPLY;
				end
			end
			smpc_pkg::ST_APPLY: begin
				// wait here until the output word slot is free
				if (out_free) begin
					cmd.apply_saved = 1'b1;
					state_n         = smpc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = smpc_pkg::ST_IDLE;
			end
		endcase

		if (cmd.apply_live || cmd.apply_saved) begin
			out_valid_n = 1'b1;
		end else if (out_ready) begin
			out_valid_n = 1'b0;
		end else begin
			out_valid_n = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/smpc_dp.sv =====
module smpc_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  smpc_pkg::smpc_cmd_t               cmd,
	output smpc_pkg::smpc_sts_t               sts,
	input  smpc_pkg::action_t                 action,
	input  logic [smpc_pkg::PULSE_BITS-1:0]   pulse_count,
	input  logic [smpc_pkg::RPM_BITS-1:0]     speed_rpm,
	input  logic                              home_level,
	input  logic                              end_level,
	input  logic [smpc_pkg::SPR_BITS-1:0]     steps_per_rev,
	input  logic [smpc_pkg::MST_BITS-1:0]     microstep,
	output logic                              step_out,
	output logic                              dir_out,
	output logic                              drive_enabled,
	output logic                              busy_res,
	output logic                              move_done,
	output logic                              pulse_event
);

	localparam int DB = smpc_pkg::DIVIDEND_BITS;
	localparam int CB = smpc_pkg::COUNT_BITS;
	localparam int PB = smpc_pkg::PERIOD_BITS;

	// motion state
	smpc_pkg::mode_t  mode_q, mode_n;
	logic             running_q, running_n;
	logic             done_q, done_n;
	logic             timer_q, timer_n;
	logic             enable_q, enable_n;
	logic             dir_q, dir_n;
	logic [CB-1:0]    pdone_q, pdone_n, pdone_inc;
	logic [CB-1:0]    ptarget_q, ptarget_n;
	logic [PB-1:0]    reload_q, reload_n;
	logic [PB-1:0]    count_q, count_n;
	logic             event_n, step_n;
	logic             halt, start;

	// command held across the period computation
	smpc_pkg::action_t                 act_sv_q;
	logic [smpc_pkg::PULSE_BITS-1:0]   pulses_sv_q;
	logic [smpc_pkg::RPM_BITS-1:0]     rpm_sv_q;

	smpc_pkg::action_t                 act;
	logic [smpc_pkg::PULSE_BITS-1:0]   pul;

	// period divider
	logic [smpc_pkg::P1_BITS-1:0]      p1_q;
	logic [smpc_pkg::PROD_BITS-1:0]    prod_q;
	logic [DB-1:0]                     rem_q, quo_q;
	logic [smpc_pkg::DIV_CNT_BITS-1:0] cnt_q;
	logic [DB:0]                       trial;
	logic [smpc_pkg::CMP_BITS-1:0]     trial_ext, prod_ext, diff;
	logic                              ge;
	logic [smpc_pkg::QUO_EXT_BITS-1:0] quo_ext;
	logic [PB-1:0]                     period_calc;

	assign sts.slow = (action inside {smpc_pkg::ACT_FWD, smpc_pkg::ACT_REV,
		smpc_pkg::ACT_HOME, smpc_pkg::ACT_END}) && (speed_rpm != '0);
	assign sts.div_last = (cnt_q == smpc_pkg::DIV_CNT_BITS'(DB - 1));

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			act_sv_q    <= action;
			pulses_sv_q <= pulse_count;
			rpm_sv_q    <= speed_rpm;
		end
		if (cmd.mul1) begin
			p1_q <= smpc_pkg::P1_BITS'(rpm_sv_q) * smpc_pkg::P1_BITS'(steps_per_rev);
		end
		if (cmd.mul2) begin
			prod_q <= smpc_pkg::PROD_BITS'(p1_q) * smpc_pkg::PROD_BITS'(microstep);
			rem_q  <= '0;
			quo_q  <= DB'(smpc_pkg::DIVIDEND);
			cnt_q  <= '0;
		end else if (cmd.div_step) begin
			// restoring divide, one quotient bit per cycle
			rem_q <= ge ? DB'(diff) : DB'(trial);
			quo_q <= {quo_q[DB-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_comb begin
		trial     = {rem_q, quo_q[DB-1]};
		trial_ext = smpc_pkg::CMP_BITS'(trial);
		prod_ext  = smpc_pkg::CMP_BITS'(prod_q);
		ge        = trial_ext >= prod_ext;
		diff      = trial_ext - prod_ext;
	end

	always_comb begin
		quo_ext = smpc_pkg::QUO_EXT_BITS'(quo_q);
		if (prod_q == '0) begin
			period_calc = PB'(smpc_pkg::PERIOD_MAX);
		end else if (quo_ext < smpc_pkg::QUO_EXT_BITS'(smpc_pkg::PERIOD_MIN + 1)) begin
			period_calc = PB'(smpc_pkg::PERIOD_MIN);
		end else if (quo_ext > smpc_pkg::QUO_EXT_BITS'(smpc_pkg::PERIOD_MAX + 1)) begin
			period_calc = PB'(smpc_pkg::PERIOD_MAX);
		end else begin
			period_calc = PB'(quo_ext - 1'b1);
		end
	end

	always_comb begin
		act       = cmd.apply_saved ? act_sv_q : action;
		pul       = cmd.apply_saved ? pulses_sv_q : pulse_count;
		mode_n    = mode_q;
		running_n = running_q;
		done_n    = done_q;
		timer_n   = timer_q;
		enable_n  = enable_q;
		dir_n     = dir_q;
		pdone_n   = pdone_q;
		ptarget_n = ptarget_q;
		reload_n  = cmd.apply_saved ? period_calc : reload_q;
		count_n   = count_q;
		event_n   = 1'b0;
		halt      = 1'b0;
		start     = 1'b0;
		pdone_inc = pdone_q + 1'b1;
		case (act)
			smpc_pkg::ACT_TICK: begin
				if (timer_q) begin
					// also wraps when a new period left the counter above it
					if (count_q >= reload_q) begin
						count_n = '0;
						event_n = 1'b1;
						pdone_n = pdone_inc;
						if (mode_q == smpc_pkg::MODE_PULSE && pdone_inc >= ptarget_q) begin
							halt = 1'b1;
						end
					end else begin
						count_n = count_q + 1'b1;
					end
				end
				if (mode_q == smpc_pkg::MODE_HOME && home_level) begin
					halt = 1'b1;
				end
				if (mode_q == smpc_pkg::MODE_END && end_level) begin
					halt = 1'b1;
				end
			end
			smpc_pkg::ACT_FWD, smpc_pkg::ACT_REV: begin
				ptarget_n = CB'(pul);
				pdone_n   = '0;
				mode_n    = smpc_pkg::MODE_PULSE;
				dir_n     = (act == smpc_pkg::ACT_REV);
				start     = 1'b1;
			end
			smpc_pkg::ACT_HOME: begin
				mode_n = smpc_pkg::MODE_HOME;
				dir_n  = 1'b0;
				start  = 1'b1;
			end
			smpc_pkg::ACT_END: begin
				mode_n = smpc_pkg::MODE_END;
				dir_n  = 1'b1;
				start  = 1'b1;
			end
			smpc_pkg::ACT_STOP: begin
				halt = 1'b1;
			end
			smpc_pkg::ACT_PAUSE: begin
				enable_n = 1'b0;
				timer_n  = 1'b0;
			end
			smpc_pkg::ACT_RESUME: begin
				enable_n = 1'b1;
				timer_n  = 1'b1;
			end
			default: begin
			end
		endcase
		if (halt) begin
			enable_n  = 1'b0;
			timer_n   = 1'b0;
			running_n = 1'b0;
			done_n    = 1'b1;
		end
		if (start) begin
			enable_n  = 1'b1;
			timer_n   = 1'b1;
			running_n = 1'b1;
			done_n    = 1'b0;
		end
		step_n = timer_n && (count_n < (reload_n >> 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= smpc_pkg::MODE_IDLE;
			running_q <= 1'b0;
			done_q    <= 1'b1;
			timer_q   <= 1'b0;
			enable_q  <= 1'b0;
			dir_q     <= 1'b0;
			pdone_q   <= '0;
			ptarget_q <= '0;
			reload_q  <= PB'(smpc_pkg::PERIOD_MAX);
			count_q   <= '0;
		end else if (cmd.apply_live || cmd.apply_saved) begin
			mode_q    <= mode_n;
			running_q <= running_n;
			done_q    <= done_n;
			timer_q   <= timer_n;
			enable_q  <= enable_n;
			dir_q     <= dir_n;
			pdone_q   <= pdone_n;
			ptarget_q <= ptarget_n;
			reload_q  <= reload_n;
			count_q   <= count_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply_live || cmd.apply_saved) begin
			step_out      <= step_n;
			dir_out       <= dir_n;
			drive_enabled <= enable_n;
			busy_res      <= running_n;
			move_done     <= done_n;
			pulse_event   <= event_n;
		end
	end

endmodule

// ===== sv/stepper_motion_pulse_controller.sv =====
// Step/direction pulse generator for a stepper driver.
// in_ch carries one word per call: a timer tick (action 0) or a move,
// stop, pause or resume command. out_ch returns exactly one status word
// for every accepted input word, in order.
// Ticks, stop, pause, resume and moves with zero rpm: the status word is
// valid in the cycle after acceptance, and a new word is taken every cycle
// while the sink keeps up.
// Moves with a non-zero rpm recompute the step period: a multiply in
// state MUL1 and one in MUL2, the restoring divider at one cycle per
// quotient bit (26 at a 1 MHz tick), then a write-back in state APPLY
// once the output slot is free; in_ch.ready stays low meanwhile.
// A status word that is not taken holds out_ch; in_ch.ready drops until
// the slot frees up, so nothing is dropped.
// Reset (arst_n low) stops the motor, disables the driver, sets the
// period to 65535 and the config registers to 200 steps and 16 microsteps.
// The APB port (addresses 0 and 4) writes and reads the two config
// registers; write them only while no word is in flight.
module stepper_motion_pulse_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	smpc_in_if.sink                          in_ch,
	smpc_out_if.source                       out_ch,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [smpc_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [smpc_pkg::DATA_BITS-1:0]   pwdata,
	output logic [smpc_pkg::DATA_BITS-1:0]   prdata,
	output logic                             pready
);

	logic [smpc_pkg::SPR_BITS-1:0] spr_q;
	logic [smpc_pkg::MST_BITS-1:0] mst_q;
	logic                          reg_sel;
	logic                          wr_en;
	smpc_pkg::smpc_cmd_t           cmd;
	smpc_pkg::smpc_sts_t           sts;

	assign pready  = 1'b1;
	assign reg_sel = paddr[smpc_pkg::ADDR_BITS-1];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q <= smpc_pkg::SPR_BITS'(smpc_pkg::SPR_RESET);
			mst_q <= smpc_pkg::MST_BITS'(smpc_pkg::MST_RESET);
		end else if (wr_en) begin
			if (reg_sel == smpc_pkg::REG_MST) begin
				mst_q <= pwdata[smpc_pkg::MST_BITS-1:0];
			end else begin
				spr_q <= pwdata[smpc_pkg::SPR_BITS-1:0];
			end
		end
	end

	always_comb begin
		if (reg_sel == smpc_pkg::REG_MST) begin
			prdata = smpc_pkg::DATA_BITS'(mst_q);
		end else begin
			prdata = smpc_pkg::DATA_BITS'(spr_q);
		end
	end

	smpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	smpc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.action        (in_ch.action),
		.pulse_count   (in_ch.pulse_count),
		.speed_rpm     (in_ch.speed_rpm),
		.home_level    (in_ch.home_level),
		.end_level     (in_ch.end_level),
		.steps_per_rev (spr_q),
		.microstep     (mst_q),
		.step_out      (out_ch.step_out),
		.dir_out       (out_ch.dir_out),
		.drive_enabled (out_ch.drive_enabled),
		.busy_res      (out_ch.busy_res),
		.move_done     (out_ch.move_done),
		.pulse_event   (out_ch.pulse_event)
	);

endmodule

// ===== sv/smpc_chk.sv =====
`include "stepper_motion_pulse_controller_assert.svh"

module smpc_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input smpc_pkg::action_t in_action,
	input logic              out_valid,
	input logic              out_ready,
	input logic              step_out,
	input logic              drive_enabled,
	input logic              busy_res,
	input logic              move_done
);

	// a stalled status word stays offered
	`SMPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

	// a tick never waits on the divider
	`SMPC_ASSERT_NEXT(a_tick_latency, in_valid && in_ready && in_action == smpc_pkg::ACT_TICK, out_valid)

	// the step line is only high with the driver enabled
	`SMPC_ASSERT(a_step_enabled, (out_valid && step_out) |-> drive_enabled)

	// busy and done are always opposite
	`SMPC_ASSERT(a_busy_done, out_valid |-> (busy_res != move_done))

endmodule

bind stepper_motion_pulse_controller smpc_chk u_smpc_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.in_action     (in_ch.action),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.step_out      (out_ch.step_out),
	.drive_enabled (out_ch.drive_enabled),
	.busy_res      (out_ch.busy_res),
	.move_done     (out_ch.move_done)
);

// ===== verif/tb_stepper_motion_pulse_controller.sv =====
`timescale 1ns / 1ps

module tb_stepper_motion_pulse_controller;

	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_WORDS  = 170;

	typedef struct packed {
		smpc_pkg::action_t                 action;
		logic [smpc_pkg::PULSE_BITS-1:0]   pulse_count;
		logic [smpc_pkg::RPM_BITS-1:0]     speed_rpm;
		logic                              home_level;
		logic                              end_level;
	} cmd_word_t;

	typedef struct packed {
		logic step_out;
		logic dir_out;
		logic drive_enabled;
		logic busy_res;
		logic move_done;
		logic pulse_event;
	} status_t;

	// Tracks the motor state and holds the status words still owed by the block.
	class motor_scoreboard;
		logic [smpc_pkg::SPR_BITS-1:0]    spr;
		logic [smpc_pkg::MST_BITS-1:0]    mst;
		smpc_pkg::mode_t                  mode;
		bit                               running, done, timer_on, enabled, reverse;
		logic [smpc_pkg::COUNT_BITS-1:0]  pulses_done, pulses_target;
		logic [smpc_pkg::PERIOD_BITS-1:0] reload, count;
		status_t                          pending[$];
		int                               fails, checked, pulses_seen;

		function new();
			spr = smpc_pkg::SPR_BITS'(smpc_pkg::SPR_RESET);
			mst = smpc_pkg::MST_BITS'(smpc_pkg::MST_RESET);
			mode = smpc_pkg::MODE_IDLE;
			running = 0;
			done = 1;
			timer_on = 0;
			enabled = 0;
			reverse = 0;
			pulses_done = '0;
			pulses_target = '0;
			reload = smpc_pkg::PERIOD_BITS'(smpc_pkg::PERIOD_MAX);
			count = '0;
			fails = 0;
			checked = 0;
			pulses_seen = 0;
		endfunction

		function void flag(string msg);
			fails++;
			if (fails <= 10)
				$display("ERROR @%0t: %s", $time, msg);
		endfunction

		function void set_reg(smpc_pkg::reg_idx_t idx,
				logic [smpc_pkg::DATA_BITS-1:0] value);
			if (idx == smpc_pkg::REG_SPR)
				spr = value[smpc_pkg::SPR_BITS-1:0];
			else
				mst = value[smpc_pkg::MST_BITS-1:0];
		endfunction

		function logic [smpc_pkg::DATA_BITS-1:0] reg_value(smpc_pkg::reg_idx_t idx);
			return (idx == smpc_pkg::REG_SPR) ? smpc_pkg::DATA_BITS'(spr)
				: smpc_pkg::DATA_BITS'(mst);
		endfunction

		function void set_period(logic [smpc_pkg::RPM_BITS-1:0] rpm);
			longint unsigned div, quo;
			if (rpm == 0)
				return;
			div = longint'(rpm) * longint'(spr) * longint'(mst);
			if (div == 0) begin
				reload = smpc_pkg::PERIOD_BITS'(smpc_pkg::PERIOD_MAX);
				return;
			end
			quo = (60 * longint'(smpc_pkg::TICK_HZ)) / div;
			if (quo < smpc_pkg::PERIOD_MIN + 1)
				reload = smpc_pkg::PERIOD_BITS'(smpc_pkg::PERIOD_MIN);
			else if (quo - 1 > smpc_pkg::PERIOD_MAX)
				reload = smpc_pkg::PERIOD_BITS'(smpc_pkg::PERIOD_MAX);
			else
				reload = smpc_pkg::PERIOD_BITS'(quo - 1);
		endfunction

		function void halt();
			enabled = 0;
			timer_on = 0;
			running = 0;
			done = 1;
		endfunction

		function void start(smpc_pkg::mode_t m, bit rev, logic [smpc_pkg::RPM_BITS-1:0] rpm);
			reverse = rev;
			mode = m;
			running = 1;
			done = 0;
			enabled = 1;
			set_period(rpm);
			timer_on = 1;
		endfunction

		// Advance the motor by one accepted word and queue the status it yields.
		function void take_word(cmd_word_t w);
			status_t st;
			bit pulse;
			pulse = 0;
			case (w.action)
				smpc_pkg::ACT_TICK: begin
					if (timer_on) begin
						// also covers a counter left above a freshly shortened period
						if (count >= reload) begin
							count = '0;
							pulse = 1;
							pulses_done = pulses_done + 1'b1;
							if (mode == smpc_pkg::MODE_PULSE && pulses_done >= pulses_target)
								halt();
						end else begin
							count = count + 1'b1;
						end
					end
					if (mode == smpc_pkg::MODE_HOME && w.home_level)
						halt();
					if (mode == smpc_pkg::MODE_END && w.end_level)
						halt();
				end
				smpc_pkg::ACT_FWD, smpc_pkg::ACT_REV: begin
					pulses_target = smpc_pkg::COUNT_BITS'(w.pulse_count);
					pulses_done = '0;
					start(smpc_pkg::MODE_PULSE, w.action == smpc_pkg::ACT_REV, w.speed_rpm);
				end
				smpc_pkg::ACT_HOME: start(smpc_pkg::MODE_HOME, 0, w.speed_rpm);
				smpc_pkg::ACT_END: start(smpc_pkg::MODE_END, 1, w.speed_rpm);
				smpc_pkg::ACT_STOP: halt();
				smpc_pkg::ACT_PAUSE: begin
					enabled = 0;
					timer_on = 0;
				end
				smpc_pkg::ACT_RESUME: begin
					enabled = 1;
					timer_on = 1;
				end
				default: ;
			endcase
			st.step_out      = timer_on && (count < (reload >> 1));
			st.dir_out       = reverse;
			st.drive_enabled = enabled;
			st.busy_res      = running;
			st.move_done     = done;
			st.pulse_event   = pulse;
			pending.push_back(st);
		endfunction

		function void check_status(status_t got);
			status_t exp;
			if (pending.size() == 0) begin
				flag("status word with nothing outstanding");
				return;
			end
			exp = pending.pop_front();
			checked++;
			if (got.pulse_event === 1'b1)
				pulses_seen++;
			if (got !== exp)
				flag($sformatf({"status exp step=%b dir=%b en=%b busy=%b done=%b pulse=%b",
					" got step=%b dir=%b en=%b busy=%b done=%b pulse=%b"},
					exp.step_out, exp.dir_out, exp.drive_enabled, exp.busy_res,
					exp.move_done, exp.pulse_event, got.step_out, got.dir_out,
					got.drive_enabled, got.busy_res, got.move_done, got.pulse_event));
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [smpc_pkg::ADDR_BITS-1:0] paddr;
	logic [smpc_pkg::DATA_BITS-1:0] pwdata;
	logic [smpc_pkg::DATA_BITS-1:0] prdata;
	logic                           pready;
	logic                           rx_hold;

	int words_sent;
	int settings_used;
	motor_scoreboard sb;

	smpc_in_if  in_ch();
	smpc_out_if out_ch();

	stepper_motion_pulse_controller u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// idle plan: sender 26 / receiver 47, then swapped, then no idling
	function automatic int tx_gap_pct();
		if (words_sent < 400)
			return 26;
		else if (words_sent < 800)
			return 47;
		return 0;
	endfunction

	function automatic int rx_stall_pct();
		if (words_sent < 400)
			return 47;
		else if (words_sent < 800)
			return 26;
		return 0;
	endfunction

	function automatic cmd_word_t random_word();
		cmd_word_t w;
		w.action      = smpc_pkg::action_t'($urandom_range(int'(smpc_pkg::ACT_RESUME)));
		w.pulse_count = smpc_pkg::PULSE_BITS'($urandom);
		w.speed_rpm   = smpc_pkg::RPM_BITS'($urandom);
		w.home_level  = 1'($urandom_range(1));
		w.end_level   = 1'($urandom_range(1));
		return w;
	endfunction

	function automatic cmd_word_t tick_word();
		cmd_word_t w;
		w = random_word();
		w.action     = smpc_pkg::ACT_TICK;
		w.home_level = ($urandom_range(99) < 4);
		w.end_level  = ($urandom_range(99) < 4);
		return w;
	endfunction

	task automatic send_word(input cmd_word_t w);
		while ($urandom_range(99) < tx_gap_pct()) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.action      <= w.action;
		in_ch.pulse_count <= w.pulse_count;
		in_ch.speed_rpm   <= w.speed_rpm;
		in_ch.home_level  <= w.home_level;
		in_ch.end_level   <= w.end_level;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sb.take_word(w);
		words_sent++;
	endtask

	task automatic send_cmd(input smpc_pkg::action_t act, input int cnt, input int rpm,
			input bit home_lvl, input bit end_lvl);
		cmd_word_t w;
		w.action      = act;
		w.pulse_count = smpc_pkg::PULSE_BITS'(cnt);
		w.speed_rpm   = smpc_pkg::RPM_BITS'(rpm);
		w.home_level  = home_lvl;
		w.end_level   = end_lvl;
		send_word(w);
	endtask

	task automatic apb_write(input smpc_pkg::reg_idx_t idx,
			input logic [smpc_pkg::DATA_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= smpc_pkg::ADDR_BITS'(4 * int'(idx));
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		sb.set_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_check(input smpc_pkg::reg_idx_t idx);
		logic [smpc_pkg::DATA_BITS-1:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= smpc_pkg::ADDR_BITS'(4 * int'(idx));
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== sb.reg_value(idx))
			sb.flag($sformatf("register %s read 0x%0h, exp 0x%0h", idx.name(), got,
				sb.reg_value(idx)));
		@(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input int spr_val, input int mst_val);
		drain();
		apb_write(smpc_pkg::REG_SPR, smpc_pkg::DATA_BITS'(spr_val));
		apb_write(smpc_pkg::REG_MST, smpc_pkg::DATA_BITS'(mst_val));
		apb_check(smpc_pkg::REG_SPR);
		apb_check(smpc_pkg::REG_MST);
		settings_used++;
	endtask

	// Mostly whole moves: a command with random content, then a run of ticks
	// with rare limit hits and stray commands; the rest is loose noise.
	task automatic run_traffic(input int n);
		cmd_word_t w;
		int stop_at;
		int pick;
		stop_at = words_sent + n;
		while (words_sent < stop_at) begin
			if ($urandom_range(99) < 70) begin
				w = random_word();
				w.action = smpc_pkg::action_t'($urandom_range(int'(smpc_pkg::ACT_FWD),
					int'(smpc_pkg::ACT_END)));
				if ($urandom_range(4) != 0)
					w.pulse_count = smpc_pkg::PULSE_BITS'($urandom_range(6));
				pick = $urandom_range(19);
				if (pick < 3)
					w.speed_rpm = '0;
				else if (pick < 12)
					w.speed_rpm = smpc_pkg::RPM_BITS'($urandom_range(2000, 4095));
				send_word(w);
				repeat ($urandom_range(5, 90)) begin
					if (words_sent >= stop_at)
						break;
					if ($urandom_range(99) < 4)
						send_word(random_word());
					else
						send_word(tick_word());
				end
			end else begin
				send_word(random_word());
			end
		end
	endtask

	initial begin : rx_side
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready)
				sb.check_status('{out_ch.step_out, out_ch.dir_out, out_ch.drive_enabled,
					out_ch.busy_res, out_ch.move_done, out_ch.pulse_event});
			out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct());
		end
	end

	// long receiver stall so the output slot fills and in_ch backs up
	initial begin : rx_hold_off
		rx_hold <= 1'b0;
		wait (words_sent >= 300);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin : watchdog
		#10_000_000;
		$display("timeout: %0d status words still outstanding", sb.pending.size());
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		sb = new();
		words_sent = 0;
		settings_used = 1;
		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		in_ch.valid       <= 1'b0;
		in_ch.action      <= smpc_pkg::ACT_TICK;
		in_ch.pulse_count <= '0;
		in_ch.speed_rpm   <= '0;
		in_ch.home_level  <= 1'b0;
		in_ch.end_level   <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_check(smpc_pkg::REG_SPR);
		apb_check(smpc_pkg::REG_MST);

		// directed: every command, field extremes, seeks, resume while idle
		send_cmd(smpc_pkg::ACT_TICK, 0, 0, 0, 0);
		send_cmd(smpc_pkg::ACT_RESUME, 0, 0, 0, 0);
		send_cmd(smpc_pkg::ACT_TICK, 0, 0, 0, 0);
		send_cmd(smpc_pkg::ACT_PAUSE, 0, 0, 0, 0);
		send_cmd(smpc_pkg::ACT_REV, 24'hFFFFFF, 0, 1, 1);
		send_cmd(smpc_pkg::ACT_TICK, 24'hFFFFFF, 12'hFFF, 1, 1);
		send_cmd(smpc_pkg::ACT_FWD, 0, 4095, 0, 0);
		send_cmd(smpc_pkg::ACT_TICK, 0, 0, 0, 0);
		send_cmd(smpc_pkg::ACT_HOME, 0, 1, 0, 0);
		send_cmd(smpc_pkg::ACT_TICK, 0, 0, 0, 1);
		send_cmd(smpc_pkg::ACT_TICK, 0, 0, 1, 0);
		send_cmd(smpc_pkg::ACT_END, 0, 4095, 0, 0);
		send_cmd(smpc_pkg::ACT_TICK, 0, 0, 1, 0);
		send_cmd(smpc_pkg::ACT_TICK, 0, 0, 0, 1);
		send_cmd(smpc_pkg::ACT_TICK, 0, 0, 0, 1);
		send_cmd(smpc_pkg::ACT_FWD, 1, 1, 0, 0);
		send_cmd(smpc_pkg::ACT_STOP, 0, 0, 0, 0);
		send_cmd(smpc_pkg::ACT_RESUME, 0, 0, 0, 0);
		send_cmd(smpc_pkg::ACT_TICK, 0, 0, 0, 0);
		send_cmd(smpc_pkg::ACT_PAUSE, 0, 0, 0, 0);
		send_cmd(smpc_pkg::ACT_TICK, 0, 0, 0, 0);
		send_cmd(smpc_pkg::ACT_RESUME, 0, 0, 0, 0);
		send_cmd(smpc_pkg::ACT_TICK, 0, 0, 0, 0);
		send_cmd(smpc_pkg::ACT_FWD, 2, 4095, 0, 0);
		send_cmd(smpc_pkg::ACT_TICK, 0, 0, 0, 0);

		run_traffic(PHASE_WORDS);
		program_regs(1, 1);
		run_traffic(PHASE_WORDS);
		program_regs(1024, 256);
		run_traffic(PHASE_WORDS);
		program_regs(0, 16);
		run_traffic(PHASE_WORDS);
		program_regs(2047, 511);
		run_traffic(PHASE_WORDS);
		program_regs(200, 0);
		run_traffic(PHASE_WORDS);
		program_regs($urandom_range(1, 1024), $urandom_range(1, 256));
		run_traffic(PHASE_WORDS);

		drain();
		$display("Ran %0d words over %0d register settings; %0d status words checked.",
			words_sent, settings_used, sb.checked);
		$display("Saw %0d step pulses; %0d mismatches.", sb.pulses_seen, sb.fails);
		if (sb.fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/smpc_pkg.sv
sv/smpc_if.sv
sv/smpc_ctrl.sv
sv/smpc_dp.sv
sv/stepper_motion_pulse_controller.sv
sv/smpc_chk.sv
verif/tb_stepper_motion_pulse_controller.sv
